>>> rtl/core/fts_pkg.sv
// Shared types and codes for the cooperative thread scheduler.
// Used by fts_sched and the top level fifo_thread_scheduler_mutex; depends on nothing.
package fts_pkg;

  // Field widths of the event and result items.
  localparam int OP_W     = 3;
  localparam int MUTEX_W  = 2;
  localparam int DATA_W   = 16;
  localparam int STATUS_W = 3;
  localparam int THREAD_W = 3;
  localparam int SPAWN_W  = 2;

  // Event codes.
  localparam logic [OP_W-1:0] OP_SPAWN  = 3'd0;
  localparam logic [OP_W-1:0] OP_YIELD  = 3'd1;
  localparam logic [OP_W-1:0] OP_LOCK   = 3'd2;
  localparam logic [OP_W-1:0] OP_UNLOCK = 3'd3;
  localparam logic [OP_W-1:0] OP_EXIT   = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_READY_EMPTY = 3'd2;
  localparam logic [STATUS_W-1:0] ST_HALTED      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MAIN_EXIT   = 3'd4;

  // Result of one event, as computed by the scheduler state logic.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [THREAD_W-1:0] running_thread;
    logic [SPAWN_W-1:0]  spawned_thread;
    logic                switched;
    logic                first_run;
    logic                run_pool;   // running thread is a pool slot, not main
  } fts_result_t;

endpackage

>>> rtl/core/fifo_thread_scheduler_mutex.sv
// Top level of the cooperative round-robin thread scheduler with FIFO mutexes.
// Depends on fts_pkg, fts_sched and fts_ram.

// Each accepted item is one scheduling event (spawn, yield, lock, unlock or exit) and
// produces exactly one result item. The block accepts one item per cycle as long as
// the result register is empty or being collected. An accepted item waits in the input
// register while the free list, ready queue and mutex queues are updated in a single
// pass of head and tail pointer logic. When the result register frees, it and the
// registered read of the entry and argument store load together. The result register
// decouples the output side, so a new item is taken while a finished result waits to
// be collected. Once a halt condition is seen, every later event answers with status
// halted until reset.
module fifo_thread_scheduler_mutex #(
  parameter int POOL_THREADS = 4,
  parameter int MUTEX_COUNT  = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [fts_pkg::OP_W-1:0]            op,
  input  logic [fts_pkg::MUTEX_W-1:0]         mutex_index,
  input  logic [fts_pkg::DATA_W-1:0]          entry_address,
  input  logic signed [fts_pkg::DATA_W-1:0]   entry_argument,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [fts_pkg::STATUS_W-1:0]        status,
  output logic [fts_pkg::THREAD_W-1:0]        running_thread,
  output logic [fts_pkg::SPAWN_W-1:0]         spawned_thread,
  output logic                                switched,
  output logic                                first_run,
  output logic [fts_pkg::DATA_W-1:0]          run_entry,
  output logic signed [fts_pkg::DATA_W-1:0]   run_argument
);

  localparam int SlotW  = (POOL_THREADS > 1) ? $clog2(POOL_THREADS) : 1;
  localparam int StoreW = 2 * fts_pkg::DATA_W;

  // Input register.
  logic                          a_valid;
  logic [fts_pkg::OP_W-1:0]      a_op;
  logic [fts_pkg::MUTEX_W-1:0]   a_mutex;
  logic [fts_pkg::DATA_W-1:0]    a_entry;
  logic [fts_pkg::DATA_W-1:0]    a_arg;

  // Result register.
  logic                          b_valid;
  fts_pkg::fts_result_t          b_res;

  fts_pkg::fts_result_t          res;
  logic [SlotW-1:0]              rd_slot;
  logic [SlotW-1:0]              wr_slot;
  logic                          wr_en;
  logic [StoreW-1:0]             store_rdata;
  logic                          advance;

  // An item moves from the input register to the result register when the latter frees.
  assign advance  = a_valid && (!b_valid || out_ready);
  assign in_ready = !a_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      a_op    <= op;
      a_mutex <= mutex_index;
      a_entry <= entry_address;
      a_arg   <= entry_argument;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (advance) begin
      b_valid <= 1'b1;
    end else if (out_ready) begin
      b_valid <= 1'b0;
    end
    if (advance) begin
      b_res <= res;
    end
  end

  // Scheduler state and event logic.
  fts_sched #(
    .POOL_THREADS(POOL_THREADS),
    .MUTEX_COUNT (MUTEX_COUNT)
  ) u_sched (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .op         (a_op),
    .mutex_index(a_mutex),
    .res        (res),
    .rd_slot    (rd_slot),
    .wr_en      (wr_en),
    .wr_slot    (wr_slot)
  );

  // Entry address and argument of each pool thread.
  fts_ram #(
    .WIDTH(StoreW),
    .DEPTH(POOL_THREADS)
  ) u_store (
    .clk  (clk),
    .we   (advance && wr_en),
    .waddr(wr_slot),
    .wdata({a_entry, a_arg}),
    .re   (advance),
    .raddr(rd_slot),
    .rdata(store_rdata)
  );

  // Result ports; the main thread reports zero entry and argument.
  assign out_valid      = b_valid;
  assign status         = b_res.status;
  assign running_thread = b_res.running_thread;
  assign spawned_thread = b_res.spawned_thread;
  assign switched       = b_res.switched;
  assign first_run      = b_res.first_run;
  assign run_entry      = b_res.run_pool ? store_rdata[StoreW-1:fts_pkg::DATA_W] : '0;
  assign run_argument   = b_res.run_pool ? store_rdata[fts_pkg::DATA_W-1:0] : '0;

`ifndef SYNTHESIS
  // The input side only stalls when both registers are full.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (a_valid && b_valid))
    else $error("input stalled while a register stage was free");

  // A thread switch only happens on a successful event.
  a_switch_ok: assert property (@(posedge clk) disable iff (rst)
    (b_valid && b_res.switched) |-> (b_res.status == fts_pkg::ST_OK))
    else $error("thread switch reported with a failing status");

  // A first run is always a switch to a pool thread.
  a_first_switch: assert property (@(posedge clk) disable iff (rst)
    (b_valid && b_res.first_run) |-> (b_res.switched && b_res.run_pool))
    else $error("first run flagged without a switch to a pool thread");

  // Halt is sticky: the event after a halting one reports halted.
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    (advance && b_valid &&
     (b_res.status == fts_pkg::ST_NO_FREE || b_res.status == fts_pkg::ST_READY_EMPTY ||
      b_res.status == fts_pkg::ST_HALTED))
    |=> (b_res.status == fts_pkg::ST_HALTED))
    else $error("event after a halt did not report halted");
`endif

endmodule

>>> rtl/core/fts_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the entry address and argument of each pool thread; no dependencies.
module fts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/fts_sched.sv
// Scheduler state: free list, ready queue, mutexes with FIFO wait queues, halt flag.
// Computes the next state and the result of one event in a single pass; uses fts_pkg.
module fts_sched #(
  parameter int POOL_THREADS = 4,
  parameter int MUTEX_COUNT  = 4,
  localparam int IdW   = $clog2(POOL_THREADS + 2),
  localparam int SlotW = (POOL_THREADS > 1) ? $clog2(POOL_THREADS) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic [fts_pkg::OP_W-1:0]     op,
  input  logic [fts_pkg::MUTEX_W-1:0]  mutex_index,
  output fts_pkg::fts_result_t         res,
  output logic [SlotW-1:0]             rd_slot,
  output logic                         wr_en,
  output logic [SlotW-1:0]             wr_slot
);

  localparam int Nodes = POOL_THREADS + 1;
  localparam int NodeW = $clog2(Nodes);
  localparam int MutW  = (MUTEX_COUNT > 1) ? $clog2(MUTEX_COUNT) : 1;
  localparam logic [IdW-1:0] MainId = IdW'(POOL_THREADS);
  localparam logic [IdW-1:0] NoneId = IdW'(POOL_THREADS + 1);

  // Next-pointer table shared by all queues; main thread is node POOL_THREADS.
  logic [IdW-1:0]          link [Nodes];
  logic [IdW-1:0]          link_next [Nodes];
  logic [IdW-1:0]          free_head, free_head_next;
  logic [IdW-1:0]          free_tail, free_tail_next;
  logic [IdW-1:0]          ready_head, ready_head_next;
  logic [IdW-1:0]          ready_tail, ready_tail_next;
  logic [IdW-1:0]          running, running_next;
  logic [MUTEX_COUNT-1:0]  held, held_next;
  logic [IdW-1:0]          waiter_head [MUTEX_COUNT];
  logic [IdW-1:0]          waiter_head_next [MUTEX_COUNT];
  logic [IdW-1:0]          waiter_tail [MUTEX_COUNT];
  logic [IdW-1:0]          waiter_tail_next [MUTEX_COUNT];
  logic [POOL_THREADS-1:0] has_run, has_run_next;
  logic                    halted, halted_next;

  logic [IdW-1:0]  slot_id;
  logic [IdW-1:0]  head_id;
  logic [MutW-1:0] mi;
  logic            mutex_ok;
  logic            sw;

  // Next state and result of the event held in the input register.
  always_comb begin
    link_next        = link;
    free_head_next   = free_head;
    free_tail_next   = free_tail;
    ready_head_next  = ready_head;
    ready_tail_next  = ready_tail;
    running_next     = running;
    held_next        = held;
    waiter_head_next = waiter_head;
    waiter_tail_next = waiter_tail;
    has_run_next     = has_run;
    halted_next      = halted;
    res              = '0;
    res.status       = fts_pkg::ST_OK;
    wr_en            = 1'b0;
    slot_id          = free_head;
    head_id          = ready_head;
    mi               = MutW'(mutex_index);
    mutex_ok         = (32'(mutex_index) < MUTEX_COUNT);

    if (halted) begin
      res.status = fts_pkg::ST_HALTED;
    end else begin
      case (op)
        fts_pkg::OP_SPAWN: begin
          if (free_head >= MainId) begin
            res.status  = fts_pkg::ST_NO_FREE;
            halted_next = 1'b1;
          end else begin
            // Take the free list head.
            slot_id        = free_head;
            free_head_next = link_next[slot_id[NodeW-1:0]];
            if (free_head_next >= NoneId) begin
              free_head_next = NoneId;
              free_tail_next = NoneId;
            end
            wr_en = 1'b1;
            has_run_next[slot_id[SlotW-1:0]] = 1'b0;
            res.spawned_thread = fts_pkg::SPAWN_W'(slot_id);
            // Append it to the ready queue.
            link_next[slot_id[NodeW-1:0]] = NoneId;
            if (ready_head_next >= NoneId) begin
              ready_head_next = slot_id;
            end else if (ready_tail_next < NoneId) begin
              link_next[ready_tail_next[NodeW-1:0]] = slot_id;
            end
            ready_tail_next = slot_id;
          end
        end

        fts_pkg::OP_YIELD: begin
          // Requeue the running thread, then run the ready head.
          link_next[running[NodeW-1:0]] = NoneId;
          if (ready_head_next >= NoneId) begin
            ready_head_next = running;
          end else if (ready_tail_next < NoneId) begin
            link_next[ready_tail_next[NodeW-1:0]] = running;
          end
          ready_tail_next = running;
          head_id = ready_head_next;
          running_next = head_id;
          ready_head_next = link_next[head_id[NodeW-1:0]];
          if (ready_head_next >= NoneId) begin
            ready_head_next = NoneId;
            ready_tail_next = NoneId;
          end
        end

        fts_pkg::OP_LOCK: begin
          if (mutex_ok) begin
            if (!held[mi]) begin
              held_next[mi] = 1'b1;
            end else if (ready_head >= NoneId) begin
              res.status  = fts_pkg::ST_READY_EMPTY;
              halted_next = 1'b1;
            end else begin
              // Park the running thread on the mutex wait queue.
              link_next[running[NodeW-1:0]] = NoneId;
              if (waiter_head_next[mi] >= NoneId) begin
                waiter_head_next[mi] = running;
              end else if (waiter_tail_next[mi] < NoneId) begin
                link_next[waiter_tail_next[mi][NodeW-1:0]] = running;
              end
              waiter_tail_next[mi] = running;
              head_id = ready_head_next;
              running_next = head_id;
              ready_head_next = link_next[head_id[NodeW-1:0]];
              if (ready_head_next >= NoneId) begin
                ready_head_next = NoneId;
                ready_tail_next = NoneId;
              end
            end
          end
        end

        fts_pkg::OP_UNLOCK: begin
          if (mutex_ok) begin
            if (waiter_head[mi] < NoneId) begin
              // Hand the mutex to the first waiter; the unlocker goes to the ready queue.
              link_next[running[NodeW-1:0]] = NoneId;
              if (ready_head_next >= NoneId) begin
                ready_head_next = running;
              end else if (ready_tail_next < NoneId) begin
                link_next[ready_tail_next[NodeW-1:0]] = running;
              end
              ready_tail_next = running;
              head_id = waiter_head_next[mi];
              running_next = head_id;
              waiter_head_next[mi] = link_next[head_id[NodeW-1:0]];
              if (waiter_head_next[mi] >= NoneId) begin
                waiter_head_next[mi] = NoneId;
                waiter_tail_next[mi] = NoneId;
              end
            end else begin
              held_next[mi] = 1'b0;
            end
          end
        end

        fts_pkg::OP_EXIT: begin
          if (running >= MainId) begin
            res.status = fts_pkg::ST_MAIN_EXIT;
          end else if (ready_head >= NoneId) begin
            res.status  = fts_pkg::ST_READY_EMPTY;
            halted_next = 1'b1;
          end else begin
            // Return the thread to the free list and run the ready head.
            link_next[running[NodeW-1:0]] = NoneId;
            if (free_head_next >= NoneId) begin
              free_head_next = running;
            end else if (free_tail_next < NoneId) begin
              link_next[free_tail_next[NodeW-1:0]] = running;
            end
            free_tail_next = running;
            head_id = ready_head_next;
            running_next = head_id;
            ready_head_next = link_next[head_id[NodeW-1:0]];
            if (ready_head_next >= NoneId) begin
              ready_head_next = NoneId;
              ready_tail_next = NoneId;
            end
          end
        end

        default: begin
        end
      endcase
    end

    if (running_next >= NoneId) begin
      running_next = MainId;
    end

    // Mark a thread as started the first time it is switched to.
    sw = (running_next != running);
    res.switched = sw;
    if (sw && (running_next < MainId)) begin
      res.first_run = !has_run_next[running_next[SlotW-1:0]];
      has_run_next[running_next[SlotW-1:0]] = 1'b1;
    end

    res.running_thread = fts_pkg::THREAD_W'(running_next);
    res.run_pool       = (running_next < MainId);
    rd_slot            = running_next[SlotW-1:0];
    wr_slot            = slot_id[SlotW-1:0];
  end

  // Scheduler state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Nodes; i++) begin
        link[i] <= (i < POOL_THREADS - 1) ? IdW'(i + 1) : NoneId;
      end
      free_head  <= '0;
      free_tail  <= IdW'(POOL_THREADS - 1);
      ready_head <= NoneId;
      ready_tail <= NoneId;
      running    <= MainId;
      held       <= '0;
      for (int j = 0; j < MUTEX_COUNT; j++) begin
        waiter_head[j] <= NoneId;
        waiter_tail[j] <= NoneId;
      end
      has_run    <= '0;
      halted     <= 1'b0;
    end else if (step) begin
      link        <= link_next;
      free_head   <= free_head_next;
      free_tail   <= free_tail_next;
      ready_head  <= ready_head_next;
      ready_tail  <= ready_tail_next;
      running     <= running_next;
      held        <= held_next;
      waiter_head <= waiter_head_next;
      waiter_tail <= waiter_tail_next;
      has_run     <= has_run_next;
      halted      <= halted_next;
    end
  end

endmodule

>>> tb/sv/fifo_thread_scheduler_mutex_test.sv
// Self-checking testbench for the cooperative thread scheduler with FIFO mutexes.
// Depends on fts_pkg and the top level fifo_thread_scheduler_mutex; a built-in
// scheduler model predicts every result item and a scoreboard queue checks them.
module fifo_thread_scheduler_mutex_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Pool geometry and thread ids as the block is configured here.
  localparam int POOL_N  = 4;
  localparam int MUTEX_N = 4;
  localparam logic [2:0] MAIN_ID = 3'd4;
  localparam logic [2:0] NO_ID   = 3'd5;

  // Queue numbers for the predictor's linked lists: free list, ready queue, then
  // one wait queue per mutex.
  localparam int FREE_Q  = 0;
  localparam int READY_Q = 1;
  localparam int WAIT_Q0 = 2;

  // Op codes that the block ignores.
  localparam logic [fts_pkg::OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [fts_pkg::OP_W-1:0] OP_UNUSED_HI = 3'd7;

  localparam int RANDOM_ITEMS = 1600;

  typedef struct packed {
    logic [fts_pkg::STATUS_W-1:0] status;
    logic [fts_pkg::THREAD_W-1:0] running;
    logic [fts_pkg::SPAWN_W-1:0]  spawned;
    logic                         sw;
    logic                         first;
    logic [fts_pkg::DATA_W-1:0]   entry;
    logic [fts_pkg::DATA_W-1:0]   arg;
  } sched_result_t;

  typedef struct packed {
    logic [fts_pkg::OP_W-1:0]    op;
    logic [fts_pkg::MUTEX_W-1:0] mi;
    logic [fts_pkg::DATA_W-1:0]  ea;
    logic [fts_pkg::DATA_W-1:0]  arg;
    logic                        typed;
    sched_result_t               want;
  } stim_row_t;

  localparam sched_result_t MAIN_IDLE =
    '{fts_pkg::ST_OK, MAIN_ID, 2'd0, 1'b0, 1'b0, 16'h0, 16'h0};
  localparam sched_result_t MAIN_EXIT_RES =
    '{fts_pkg::ST_MAIN_EXIT, MAIN_ID, 2'd0, 1'b0, 1'b0, 16'h0, 16'h0};

  // Directed events: reset behavior, field extremes, contention and hand-off.
  localparam int DIRECTED_N = 25;
  localparam stim_row_t DIRECTED [DIRECTED_N] = '{
    '{fts_pkg::OP_YIELD,  2'd0, 16'h1234, 16'h4321, 1'b1, MAIN_IDLE},
    '{fts_pkg::OP_EXIT,   2'd0, 16'hFFFF, 16'hFFFF, 1'b1, MAIN_EXIT_RES},
    '{OP_UNUSED_LO,       2'd3, 16'hFFFF, 16'h8000, 1'b1, MAIN_IDLE},
    '{OP_UNUSED_HI,       2'd1, 16'h0000, 16'h7FFF, 1'b1, MAIN_IDLE},
    '{fts_pkg::OP_UNLOCK, 2'd3, 16'h5A5A, 16'hA5A5, 1'b1, MAIN_IDLE},
    '{fts_pkg::OP_SPAWN,  2'd0, 16'hFFFF, 16'h8000, 1'b1, MAIN_IDLE},
    '{fts_pkg::OP_SPAWN,  2'd3, 16'h0000, 16'h7FFF, 1'b1,
      '{fts_pkg::ST_OK, MAIN_ID, 2'd1, 1'b0, 1'b0, 16'h0, 16'h0}},
    '{fts_pkg::OP_SPAWN,  2'd1, 16'h8000, 16'hFFFF, 1'b1,
      '{fts_pkg::ST_OK, MAIN_ID, 2'd2, 1'b0, 1'b0, 16'h0, 16'h0}},
    '{fts_pkg::OP_SPAWN,  2'd2, 16'h7FFF, 16'h0000, 1'b1,
      '{fts_pkg::ST_OK, MAIN_ID, 2'd3, 1'b0, 1'b0, 16'h0, 16'h0}},
    '{fts_pkg::OP_LOCK,   2'd0, 16'h0F0F, 16'hF0F0, 1'b1, MAIN_IDLE},
    '{fts_pkg::OP_YIELD,  2'd0, 16'h0000, 16'h0000, 1'b0, '0},
    '{fts_pkg::OP_LOCK,   2'd0, 16'h0000, 16'h0000, 1'b0, '0},
    '{fts_pkg::OP_LOCK,   2'd0, 16'hFFFF, 16'hFFFF, 1'b0, '0},
    '{fts_pkg::OP_UNLOCK, 2'd0, 16'h0000, 16'h0000, 1'b0, '0},
    '{fts_pkg::OP_UNLOCK, 2'd0, 16'h0000, 16'h0000, 1'b0, '0},
    '{fts_pkg::OP_UNLOCK, 2'd0, 16'h0000, 16'h0000, 1'b0, '0},
    '{fts_pkg::OP_LOCK,   2'd3, 16'h0000, 16'h0000, 1'b0, '0},
    '{fts_pkg::OP_EXIT,   2'd0, 16'h0000, 16'h0000, 1'b0, '0},
    '{fts_pkg::OP_YIELD,  2'd0, 16'h0000, 16'h0000, 1'b0, '0},
    '{fts_pkg::OP_SPAWN,  2'd0, 16'hAAAA, 16'h5555, 1'b0, '0},
    '{fts_pkg::OP_YIELD,  2'd0, 16'h0000, 16'h0000, 1'b0, '0},
    '{fts_pkg::OP_EXIT,   2'd0, 16'h0000, 16'h0000, 1'b0, '0},
    '{fts_pkg::OP_UNLOCK, 2'd3, 16'h0000, 16'h0000, 1'b0, '0},
    '{fts_pkg::OP_LOCK,   2'd2, 16'h0000, 16'h0000, 1'b0, '0},
    '{fts_pkg::OP_UNLOCK, 2'd1, 16'h0000, 16'h0000, 1'b0, '0}
  };

  logic                                clk = 1'b0;
  logic                                rst;
  logic                                in_valid;
  logic                                in_ready;
  logic [fts_pkg::OP_W-1:0]            op;
  logic [fts_pkg::MUTEX_W-1:0]         mutex_index;
  logic [fts_pkg::DATA_W-1:0]          entry_address;
  logic signed [fts_pkg::DATA_W-1:0]   entry_argument;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic [fts_pkg::STATUS_W-1:0]        status;
  logic [fts_pkg::THREAD_W-1:0]        running_thread;
  logic [fts_pkg::SPAWN_W-1:0]         spawned_thread;
  logic                                switched;
  logic                                first_run;
  logic [fts_pkg::DATA_W-1:0]          run_entry;
  logic signed [fts_pkg::DATA_W-1:0]   run_argument;

  // Scheduler model state.
  logic [2:0]                 next_link [0:POOL_N];
  logic [2:0]                 q_head [0:WAIT_Q0+MUTEX_N-1];
  logic [2:0]                 q_tail [0:WAIT_Q0+MUTEX_N-1];
  logic [2:0]                 running_id;
  logic                       mutex_held [0:MUTEX_N-1];
  logic [fts_pkg::DATA_W-1:0] entry_store [0:POOL_N-1];
  logic [fts_pkg::DATA_W-1:0] argument_store [0:POOL_N-1];
  logic                       has_run [0:POOL_N];
  logic                       sched_halted;

  sched_result_t pending_results [$];
  int            mismatches = 0;
  int            send_idle_pct;
  int            recv_idle_pct;

  fifo_thread_scheduler_mutex #(
    .POOL_THREADS(POOL_N),
    .MUTEX_COUNT (MUTEX_N)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .mutex_index   (mutex_index),
    .entry_address (entry_address),
    .entry_argument(entry_argument),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .running_thread(running_thread),
    .spawned_thread(spawned_thread),
    .switched      (switched),
    .first_run     (first_run),
    .run_entry     (run_entry),
    .run_argument  (run_argument)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Put the model in its reset state: all pool slots chained on the free list.
  function automatic void reset_model();
    for (int i = 0; i <= POOL_N; i++) begin
      next_link[i] = NO_ID;
      has_run[i] = 1'b0;
    end
    for (int i = 0; i < POOL_N - 1; i++) next_link[i] = 3'(i + 1);
    for (int q = 0; q < WAIT_Q0 + MUTEX_N; q++) begin
      q_head[q] = NO_ID;
      q_tail[q] = NO_ID;
    end
    q_head[FREE_Q] = 3'd0;
    q_tail[FREE_Q] = 3'(POOL_N - 1);
    for (int m = 0; m < MUTEX_N; m++) mutex_held[m] = 1'b0;
    for (int i = 0; i < POOL_N; i++) begin
      entry_store[i] = '0;
      argument_store[i] = '0;
    end
    running_id = MAIN_ID;
    has_run[MAIN_ID] = 1'b1;
    sched_halted = 1'b0;
  endfunction

  // Append a thread at the tail of one linked queue.
  function automatic void q_push(int q, logic [2:0] id);
    if (id <= POOL_N) begin
      next_link[id] = NO_ID;
      if (q_head[q] > POOL_N) q_head[q] = id;
      else if (q_tail[q] <= POOL_N) next_link[q_tail[q]] = id;
      q_tail[q] = id;
    end
  endfunction

  // Remove the head of one linked queue; an empty queue gives no thread.
  function automatic logic [2:0] q_pop(int q);
    logic [2:0] id;
    id = q_head[q];
    if (id > POOL_N) return NO_ID;
    q_head[q] = next_link[id];
    if (q_head[q] > POOL_N) begin
      q_head[q] = NO_ID;
      q_tail[q] = NO_ID;
    end
    return id;
  endfunction

  // Apply one event to the model and return the result item it should produce.
  function automatic sched_result_t schedule_event(logic [fts_pkg::OP_W-1:0] ev_op,
                                                   logic [fts_pkg::MUTEX_W-1:0] mi,
                                                   logic [fts_pkg::DATA_W-1:0] ea,
                                                   logic [fts_pkg::DATA_W-1:0] arg);
    sched_result_t r;
    logic [2:0] prev;
    logic [2:0] id;
    r = '0;
    prev = running_id;
    if (sched_halted) begin
      r.status = fts_pkg::ST_HALTED;
    end else begin
      // Every 2-bit index names an existing mutex with four mutexes.
      case (ev_op)
        fts_pkg::OP_SPAWN: begin
          if (q_head[FREE_Q] >= POOL_N) begin
            r.status = fts_pkg::ST_NO_FREE;
            sched_halted = 1'b1;
          end else begin
            id = q_pop(FREE_Q);
            entry_store[id[1:0]] = ea;
            argument_store[id[1:0]] = arg;
            has_run[id] = 1'b0;
            q_push(READY_Q, id);
            r.spawned = id[1:0];
          end
        end
        fts_pkg::OP_YIELD: begin
          q_push(READY_Q, running_id);
          running_id = q_pop(READY_Q);
        end
        fts_pkg::OP_LOCK: begin
          if (!mutex_held[mi]) begin
            mutex_held[mi] = 1'b1;
          end else if (q_head[READY_Q] > POOL_N) begin
            r.status = fts_pkg::ST_READY_EMPTY;
            sched_halted = 1'b1;
          end else begin
            q_push(WAIT_Q0 + mi, running_id);
            running_id = q_pop(READY_Q);
          end
        end
        fts_pkg::OP_UNLOCK: begin
          // With waiters the mutex stays held and passes to the first of them.
          if (q_head[WAIT_Q0 + mi] <= POOL_N) begin
            q_push(READY_Q, running_id);
            running_id = q_pop(WAIT_Q0 + mi);
          end else begin
            mutex_held[mi] = 1'b0;
          end
        end
        fts_pkg::OP_EXIT: begin
          if (running_id >= POOL_N) begin
            r.status = fts_pkg::ST_MAIN_EXIT;
          end else if (q_head[READY_Q] > POOL_N) begin
            r.status = fts_pkg::ST_READY_EMPTY;
            sched_halted = 1'b1;
          end else begin
            q_push(FREE_Q, running_id);
            running_id = q_pop(READY_Q);
          end
        end
        default: begin
        end
      endcase
    end

    if (running_id > POOL_N) running_id = MAIN_ID;
    if (running_id != prev) begin
      r.sw = 1'b1;
      r.first = !has_run[running_id];
      has_run[running_id] = 1'b1;
    end
    r.running = running_id;
    if (running_id < POOL_N) begin
      r.entry = entry_store[running_id[1:0]];
      r.arg = argument_store[running_id[1:0]];
    end
    return r;
  endfunction

  // Present one event, wait until it is taken, then record its expected result.
  task automatic send_event(logic [fts_pkg::OP_W-1:0] ev_op,
                            logic [fts_pkg::MUTEX_W-1:0] mi,
                            logic [fts_pkg::DATA_W-1:0] ea,
                            logic [fts_pkg::DATA_W-1:0] arg,
                            logic typed, sched_result_t want);
    sched_result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    op             <= ev_op;
    mutex_index    <= mi;
    entry_address  <= ea;
    entry_argument <= arg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = schedule_event(ev_op, mi, ea, arg);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic check_field(string name, logic [fts_pkg::DATA_W-1:0] want,
                             logic [fts_pkg::DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Result side: random back-pressure and a field-by-field check of each item.
  always @(posedge clk) begin : collect
    sched_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result item with no event outstanding");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 16'(want.status), 16'(status));
        check_field("running_thread", 16'(want.running), 16'(running_thread));
        check_field("spawned_thread", 16'(want.spawned), 16'(spawned_thread));
        check_field("switched", 16'(want.sw), 16'(switched));
        check_field("first_run", 16'(want.first), 16'(first_run));
        check_field("run_entry", want.entry, run_entry);
        check_field("run_argument", want.arg, run_argument);
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  initial begin
    int r;
    int counted;
    int tail_count;
    logic [fts_pkg::OP_W-1:0]    ev_op;
    logic [fts_pkg::MUTEX_W-1:0] mi;

    rst            = 1'b1;
    in_valid       = 1'b0;
    op             = fts_pkg::OP_YIELD;
    mutex_index    = '0;
    entry_address  = '0;
    entry_argument = '0;
    send_idle_pct  = 6;
    recv_idle_pct  = 51;
    reset_model();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_N; i++) begin
      send_event(DIRECTED[i].op, DIRECTED[i].mi, DIRECTED[i].ea, DIRECTED[i].arg,
                 DIRECTED[i].typed, DIRECTED[i].want);
    end

    // Random events that keep the scheduler out of its halt so that the queues
    // and mutex hand-offs get deep coverage. Ignored op codes are mixed in as noise.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (counted == RANDOM_ITEMS / 3) begin
        send_idle_pct = 51;
        recv_idle_pct = 6;
      end else if (counted == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      r = $urandom_range(0, 99);
      if (r < 18) ev_op = fts_pkg::OP_SPAWN;
      else if (r < 43) ev_op = fts_pkg::OP_YIELD;
      else if (r < 63) ev_op = fts_pkg::OP_LOCK;
      else if (r < 83) ev_op = fts_pkg::OP_UNLOCK;
      else if (r < 93) ev_op = fts_pkg::OP_EXIT;
      else ev_op = OP_UNUSED_LO + 3'($urandom_range(0, 2));
      // Contention is concentrated on two of the mutexes.
      mi = ($urandom_range(0, 3) != 0) ? 2'($urandom_range(0, 1))
                                       : 2'($urandom_range(2, 3));
      if (ev_op == fts_pkg::OP_SPAWN && q_head[FREE_Q] >= POOL_N)
        ev_op = fts_pkg::OP_YIELD;
      if (ev_op == fts_pkg::OP_LOCK && mutex_held[mi] && q_head[READY_Q] > POOL_N)
        ev_op = fts_pkg::OP_UNLOCK;
      if (ev_op == fts_pkg::OP_EXIT && running_id < POOL_N && q_head[READY_Q] > POOL_N)
        ev_op = fts_pkg::OP_YIELD;
      send_event(ev_op, mi, 16'($urandom), 16'($urandom), 1'b0, '0);
      counted++;
    end

    // Drive the scheduler into its sticky halt; which cause wins is left to chance.
    tail_count = 0;
    while (!sched_halted && tail_count < 200) begin
      r = $urandom_range(0, 99);
      if (r < 30) ev_op = fts_pkg::OP_SPAWN;
      else if (r < 65) ev_op = fts_pkg::OP_LOCK;
      else if (r < 85) ev_op = fts_pkg::OP_EXIT;
      else ev_op = fts_pkg::OP_YIELD;
      send_event(ev_op, 2'($urandom_range(0, 1)), 16'($urandom), 16'($urandom), 1'b0, '0);
      tail_count++;
    end
    // Once halted, every event must answer with the halted status.
    for (int i = 0; i < 6; i++) begin
      send_event(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)), 16'($urandom),
                 16'($urandom), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/fts_pkg.sv
rtl/core/fts_ram.sv
rtl/core/fts_sched.sv
rtl/core/fifo_thread_scheduler_mutex.sv
tb/sv/fifo_thread_scheduler_mutex_test.sv
